### sv/csm_pkg.sv
// shared types, constants and arithmetic helpers for the csr sparse matvec block
// used by csm_xmem, csm_ctrl, csm_dp and csr_sparse_matvec_axpby
package csm_pkg;

    localparam int VEC_DEPTH = 1024;
    localparam int XADDR_W   = $clog2(VEC_DEPTH);
    localparam int COL_W     = 10;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic [31:0] BETA_RESET  = 32'h0000_0000;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_ENTRY = 2'd1,
        ACT_EMPTY = 2'd2
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA = 2'd0,
        REG_BETA  = 2'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_RND,
        ST_MULA,
        ST_MULB,
        ST_SUM,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        MS_ENTRY,
        MS_ALPHA,
        MS_BETA
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     x_rd;
        logic     x_wr;
        mul_sel_t mul_sel;
        logic     prod_en;
        logic     acc_add;
        logic     acc_round;
        logic     sum_move;
        logic     sum_add;
        logic     out_load;
    } ctl_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              clip;
    } q16_t;

    typedef struct packed {
        logic [ACC_W-1:0] val;
        logic             clip;
    } sum64_t;

    // q32.32 to q16.16, nearest with ties up, clipped to 32 bits
    function automatic q16_t to_q16(input logic [ACC_W-1:0] v);
        logic [48:0] q;
        q16_t        r;
        q = {v[63], v[63:16]} + 49'(v[15]);
        if (q[48:31] == '0 || q[48:31] == '1)
        begin
            r.val  = q[31:0];
            r.clip = 1'b0;
        end
        else
        begin
            r.val  = q[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r.clip = 1'b1;
        end
        return r;
    endfunction

    // signed 64-bit add clipped at the bounds
    function automatic sum64_t sat_add64(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        sum64_t         r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            r.val  = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = s[ACC_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

### sv/csm_xmem.sv
// x vector store: single-port synchronous ram, one write or one read a cycle
// depends on csm_pkg for depth and widths
module csm_xmem (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic                        rd_en,
    input  logic [csm_pkg::COL_W-1:0]   addr,
    input  logic [csm_pkg::DATA_W-1:0]  wr_data,
    output logic [csm_pkg::DATA_W-1:0]  rd_data
);
    import csm_pkg::*;

    logic [DATA_W-1:0]  mem [VEC_DEPTH];
    logic [DATA_W-1:0]  rd_data_reg;
    logic               rd_ok_reg;
    logic               in_range;
    logic [XADDR_W-1:0] idx;

    assign in_range = (32'(addr) < VEC_DEPTH);
    assign idx      = XADDR_W'(addr);

    always_ff @(posedge clk)
    begin
        if (wr_en && in_range)
        begin
            mem[idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx];
            rd_ok_reg   <= in_range;
        end
    end

    // columns past the store read as zero
    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

### sv/csm_ctrl.sv
// sequencer: request handshake, item decode, datapath steps and output valid
// depends on csm_pkg for state, action and control types
module csm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            action,
    input  logic                  row_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output csm_pkg::ctl_t         ctl
);
    import csm_pkg::*;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;
    logic   rend_reg, rend_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            rend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            rend_reg      <= rend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        rend_next      = rend_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctl            = '0;
        ctl.mul_sel    = MS_ENTRY;
        unique case (state_reg)
            ST_IDLE:
            begin
                // finish the accumulate left over from the last entry
                ctl.acc_add = pend_reg;
                pend_next   = 1'b0;
                if (accept)
                begin
                    ctl.capture = 1'b1;
                    rend_next   = row_end;
                    unique case (action)
                        ACT_LOAD:
                        begin
                            ctl.x_wr = 1'b1;
                        end
                        ACT_ENTRY:
                        begin
                            ctl.x_rd   = 1'b1;
                            state_next = ST_MUL;
                        end
                        ACT_EMPTY:
                        begin
                            state_next = ST_RND;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                ctl.mul_sel = MS_ENTRY;
                ctl.prod_en = 1'b1;
                if (rend_reg)
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    pend_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                ctl.acc_add = 1'b1;
                state_next  = ST_RND;
            end
            ST_RND:
            begin
                ctl.acc_round = 1'b1;
                state_next    = ST_MULA;
            end
            ST_MULA:
            begin
                ctl.mul_sel = MS_ALPHA;
                ctl.prod_en = 1'b1;
                state_next  = ST_MULB;
            end
            ST_MULB:
            begin
                ctl.mul_sel  = MS_BETA;
                ctl.prod_en  = 1'b1;
                ctl.sum_move = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                ctl.sum_add = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_pend_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == ST_IDLE)
        else $error("accumulate pending outside idle");

    a_entry_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_ENTRY) |=> state_reg == ST_MUL)
        else $error("entry request did not start the multiply");

    a_fin_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("row end did not present a result");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> !(state_reg == ST_MUL && !$past(rend_reg) && pend_reg))
        else $error("multiply step repeated");

endmodule

### sv/csm_dp.sv
// datapath: gain registers, shared 32x32 multiplier, row accumulator,
// rounding and the output register; steered by csm_ctrl through ctl_t
module csm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csm_pkg::ctl_t                 ctl,
    input  logic                          cfg_wr_en,
    input  logic [csm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csm_pkg::DATA_W-1:0]    cfg_data,
    input  logic [csm_pkg::DATA_W-1:0]    entry_value,
    input  logic [csm_pkg::DATA_W-1:0]    y_value,
    input  logic                          final_row,
    input  logic [csm_pkg::DATA_W-1:0]    x_data,
    output logic [csm_pkg::DATA_W-1:0]    row_result,
    output logic                          saturated,
    output logic                          last
);
    import csm_pkg::*;

    logic [DATA_W-1:0]        alpha_reg, beta_reg;
    logic [DATA_W-1:0]        val_reg, y_reg;
    logic                     fin_reg;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [ACC_W-1:0]  mul_p;
    logic [ACC_W-1:0]         prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic                     aclip_reg;
    logic [DATA_W-1:0]        acc16_reg;
    logic [ACC_W-1:0]         sum_reg;
    logic                     rclip_reg;
    logic [DATA_W-1:0]        res_reg;
    logic                     sat_reg;
    logic                     last_reg;
    sum64_t                   acc_s, sum_s;
    q16_t                     acc_q, res_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            beta_reg  <= BETA_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_ALPHA)
            begin
                alpha_reg <= cfg_data;
            end
            if (cfg_index == REG_BETA)
            begin
                beta_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        unique case (ctl.mul_sel)
            MS_ALPHA:
            begin
                mul_a = alpha_reg;
                mul_b = acc16_reg;
            end
            MS_BETA:
            begin
                mul_a = beta_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_data;
                mul_b = val_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign acc_s = sat_add64(acc_reg, prod_reg);
    assign acc_q = to_q16(acc_reg);
    assign sum_s = sat_add64(sum_reg, prod_reg);
    assign res_q = to_q16(sum_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            val_reg <= entry_value;
            y_reg   <= y_value;
            fin_reg <= final_row;
        end
        if (ctl.prod_en)
        begin
            prod_reg <= mul_p;
        end
        if (ctl.sum_move)
        begin
            sum_reg <= prod_reg;
        end
        else if (ctl.sum_add && beta_reg != '0)
        begin
            sum_reg <= sum_s.val;
        end
        if (ctl.acc_round)
        begin
            acc16_reg <= acc_q.val;
            rclip_reg <= aclip_reg | acc_q.clip;
        end
        else if (ctl.sum_add && beta_reg != '0)
        begin
            rclip_reg <= rclip_reg | sum_s.clip;
        end
        if (ctl.out_load)
        begin
            res_reg  <= res_q.val;
            sat_reg  <= rclip_reg | res_q.clip;
            last_reg <= fin_reg;
        end
    end

    // running row sum, cleared once the row has been rounded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            aclip_reg <= 1'b0;
        end
        else if (ctl.acc_round)
        begin
            acc_reg   <= '0;
            aclip_reg <= 1'b0;
        end
        else if (ctl.acc_add)
        begin
            acc_reg   <= acc_s.val;
            aclip_reg <= aclip_reg | acc_s.clip;
        end
    end

    assign row_result = res_reg;
    assign saturated  = sat_reg;
    assign last       = last_reg;

    a_steps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctl.acc_add, ctl.acc_round, ctl.sum_add, ctl.out_load}) <= 1)
        else $error("datapath steps overlap");

    a_round_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.acc_round |=> (acc_reg == '0 && !aclip_reg))
        else $error("accumulator not cleared after row end");

    a_clip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (aclip_reg && !ctl.acc_round) |=> aclip_reg)
        else $error("accumulator clip flag lost within a row");

endmodule

### sv/csr_sparse_matvec_axpby.sv
// top level of the scaled csr sparse matrix-vector block
// depends on csm_pkg, csm_xmem, csm_ctrl and csm_dp
//
// Streams a sparse matrix in CSR order against a dense x vector held in a
// 1024 x 32 on-chip ram, and returns alpha*row_sum + beta*y per row in signed
// Q16.16 with saturation. Load x first (action 0), then send nonzeros
// (action 1, row_end on the last of a row) or empty-row items (action 2).
// A load is a ram write, and a nonzero that does not end its row a ram read
// and a multiply (the accumulate overlaps the next request). A nonzero that
// ends its row, and an empty row, go on to round and scale: the single 32x32
// multiplier is shared by the entry product, alpha and beta scaling, with a
// rounding step before and after. The result sits in an output register, so
// new requests are taken while it waits. No clearing pass after reset; x
// entries read before written return undefined data. Write gains only idle.
module csr_sparse_matvec_axpby (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [csm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [csm_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [csm_pkg::COL_W-1:0]     column,
    input  logic [csm_pkg::DATA_W-1:0]    entry_value,
    input  logic                          row_end,
    input  logic [csm_pkg::DATA_W-1:0]    y_value,
    input  logic                          final_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [csm_pkg::DATA_W-1:0]    row_result,
    output logic                          saturated,
    output logic                          last
);
    import csm_pkg::*;

    ctl_t              ctl;
    logic [DATA_W-1:0] x_data;

    csm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .row_end   (row_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    csm_xmem u_xmem (
        .clk     (clk),
        .wr_en   (ctl.x_wr),
        .rd_en   (ctl.x_rd),
        .addr    (column),
        .wr_data (entry_value),
        .rd_data (x_data)
    );

    csm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .entry_value (entry_value),
        .y_value     (y_value),
        .final_row   (final_row),
        .x_data      (x_data),
        .row_result  (row_result),
        .saturated   (saturated),
        .last        (last)
    );

endmodule
